// ----- design/hcs_pkg.sv -----
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the HSV centroid steering block.
// ----------------------------------------------------------------------------
package hcs_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ROW_WIDTH = 3'd0;
  localparam logic [2:0] REG_TOLERANCE = 3'd1;
  localparam logic [2:0] REG_HUE_MIN   = 3'd2;
  localparam logic [2:0] REG_HUE_MAX   = 3'd3;
  localparam logic [2:0] REG_SAT_MIN   = 3'd4;
  localparam logic [2:0] REG_SAT_MAX   = 3'd5;
  localparam logic [2:0] REG_VAL_MIN   = 3'd6;
  localparam logic [2:0] REG_VAL_MAX   = 3'd7;

  // Reset values
  localparam logic [10:0] RST_ROW_WIDTH = 11'd640;
  localparam logic [8:0]  RST_TOLERANCE = 9'd15;
  localparam logic [7:0]  RST_HUE_MIN   = 8'd20;
  localparam logic [7:0]  RST_HUE_MAX   = 8'd30;
  localparam logic [7:0]  RST_SAT_MIN   = 8'd100;
  localparam logic [7:0]  RST_SAT_MAX   = 8'd255;
  localparam logic [7:0]  RST_VAL_MIN   = 8'd100;
  localparam logic [7:0]  RST_VAL_MAX   = 8'd255;

  localparam int unsigned CNT_W = 21;
  localparam int unsigned SUM_W = 30;
  localparam logic [CNT_W-1:0] CNT_FIELD_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_LIMIT     = '1;

  // ceil(2^16/10); exact floor(x/10) for x < 16384
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  typedef enum logic [1:0] {
    DIR_LEFT     = 2'd0,
    DIR_STRAIGHT = 2'd1,
    DIR_RIGHT    = 2'd2,
    DIR_SEARCH   = 2'd3
  } dir_t;

  // Thresholds handed to the pixel classifier
  typedef struct packed {
    logic [7:0]  hue_min;
    logic [7:0]  hue_max;
    logic [7:0]  sat_min;
    logic [7:0]  sat_max;
    logic [7:0]  val_min;
    logic [7:0]  val_max;
    logic [10:0] band_lo;
    logic [10:0] band_hi;
  } thr_t;

  // floor(3*w/10)
  function automatic logic [10:0] band_low(input logic [10:0] w);
    logic [13:0] x;
    logic [26:0] p;
    x = {2'b00, w, 1'b0} + {3'b000, w};
    p = 27'(x) * 27'(RECIP_TEN);
    return p[26:16];
  endfunction

  // floor(7*w/10)
  function automatic logic [10:0] band_high(input logic [10:0] w);
    logic [13:0] x;
    logic [26:0] p;
    x = {w, 3'b000} - {3'b000, w};
    p = 27'(x) * 27'(RECIP_TEN);
    return p[26:16];
  endfunction

endpackage

// ----- design/hcs_classify.sv -----
// ----------------------------------------------------------------------------
// hcs_classify
// Flags a pixel as line when all three channels are inside their bounds and
// its column lies in the central band.
// ----------------------------------------------------------------------------
module hcs_classify #(
  parameter int unsigned COL_W = 10
) (
  input  hcs_pkg::thr_t     thr,
  input  logic [7:0]        hue,
  input  logic [7:0]        saturation,
  input  logic [7:0]        brightness,
  input  logic [COL_W-1:0]  column,
  output logic              hit
);

  localparam int unsigned CMP_W = (COL_W > 11) ? COL_W : 11;

  logic [CMP_W-1:0] col_ext;
  logic [CMP_W-1:0] lo_ext;
  logic [CMP_W-1:0] hi_ext;
  logic             color_ok;
  logic             band_ok;

  assign col_ext = CMP_W'(column);
  assign lo_ext  = CMP_W'(thr.band_lo);
  assign hi_ext  = CMP_W'(thr.band_hi);

  assign color_ok = (hue >= thr.hue_min) && (hue <= thr.hue_max) &&
                    (saturation >= thr.sat_min) && (saturation <= thr.sat_max) &&
                    (brightness >= thr.val_min) && (brightness <= thr.val_max);
  assign band_ok  = (col_ext >= lo_ext) && (col_ext < hi_ext);
  assign hit      = color_ok && band_ok;

endmodule

// ----- design/hsv_centroid_steering_top.sv -----
// ----------------------------------------------------------------------------
// hsv_centroid_steering_top
// Line follower: HSV threshold, central band centroid, steering direction.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per transaction, and the block takes one
// every clock while s_axis_tready is high. A pixel counts as line when hue,
// saturation and brightness are inside their inclusive bounds and its column
// is in the band [floor(3*W/10), floor(7*W/10)) with W = row_width. Count and
// column sum of line pixels are kept per frame; on the frame-end pixel (tlast)
// one result transaction gives the direction (left/straight/right, or search
// when no line pixel was seen) and the count, and the accumulators are
// cleared. The frame-end pixel lands in the input register, is accumulated,
// then the two products of the centre window bounds with the count are formed,
// and the decision is compared into the output register. The stages move
// together, and s_axis_tready drops only while a result in the product stage
// finds an earlier result still unaccepted at the output.
// Row ends (tuser) reset the column; without them the column wraps at
// MAX_WIDTH. Configuration writes take effect on the next clock and are to be
// made between frames with the pipeline empty.
// ----------------------------------------------------------------------------
module hsv_centroid_steering_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] hue, [15:8] saturation, [23:16] brightness
  input  logic        s_axis_tuser,   // [0] row_end
  input  logic        s_axis_tlast,   // frame_end
  // steering result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] direction, [22:2] line_pixels, [23] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam longint unsigned PIX_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam logic [hcs_pkg::CNT_W-1:0] COUNT_LIMIT =
    (PIX_MAX > longint'(hcs_pkg::CNT_FIELD_MAX)) ? hcs_pkg::CNT_FIELD_MAX
                                                 : hcs_pkg::CNT_W'(PIX_MAX);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

  // -------------------------------------------------------------------------
  // Configuration registers; band edges are worked out at write time.
  // -------------------------------------------------------------------------
  logic [10:0]    row_width;
  logic [8:0]     tolerance;
  hcs_pkg::thr_t  thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= hcs_pkg::RST_ROW_WIDTH;
      tolerance   <= hcs_pkg::RST_TOLERANCE;
      thr.hue_min <= hcs_pkg::RST_HUE_MIN;
      thr.hue_max <= hcs_pkg::RST_HUE_MAX;
      thr.sat_min <= hcs_pkg::RST_SAT_MIN;
      thr.sat_max <= hcs_pkg::RST_SAT_MAX;
      thr.val_min <= hcs_pkg::RST_VAL_MIN;
      thr.val_max <= hcs_pkg::RST_VAL_MAX;
      thr.band_lo <= hcs_pkg::band_low(hcs_pkg::RST_ROW_WIDTH);
      thr.band_hi <= hcs_pkg::band_high(hcs_pkg::RST_ROW_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hcs_pkg::REG_ROW_WIDTH: begin
          row_width   <= cfg_data;
          thr.band_lo <= hcs_pkg::band_low(cfg_data);
          thr.band_hi <= hcs_pkg::band_high(cfg_data);
        end
        hcs_pkg::REG_TOLERANCE: tolerance   <= cfg_data[8:0];
        hcs_pkg::REG_HUE_MIN:   thr.hue_min <= cfg_data[7:0];
        hcs_pkg::REG_HUE_MAX:   thr.hue_max <= cfg_data[7:0];
        hcs_pkg::REG_SAT_MIN:   thr.sat_min <= cfg_data[7:0];
        hcs_pkg::REG_SAT_MAX:   thr.sat_max <= cfg_data[7:0];
        hcs_pkg::REG_VAL_MIN:   thr.val_min <= cfg_data[7:0];
        hcs_pkg::REG_VAL_MAX:   thr.val_max <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline enable: everything moves unless a result in stage 3 finds the
  // output register still holding an unaccepted result.
  // -------------------------------------------------------------------------
  logic advance;
  logic in_fire;
  logic r3_valid;

  assign advance       = !(r3_valid && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // -------------------------------------------------------------------------
  // Stage 1: input register and column tracking
  // -------------------------------------------------------------------------
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic             s1_valid;
  logic [7:0]       s1_hue;
  logic [7:0]       s1_sat;
  logic [7:0]       s1_val;
  logic             s1_frame_end;
  logic [COL_W-1:0] s1_col;

  always_comb begin
    if (s_axis_tuser || s_axis_tlast || column == COL_LAST) begin
      column_next = '0;
    end else begin
      column_next = column + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        column <= column_next;
      end
      if (advance) begin
        s1_valid <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hue       <= s_axis_tdata[7:0];
      s1_sat       <= s_axis_tdata[15:8];
      s1_val       <= s_axis_tdata[23:16];
      s1_frame_end <= s_axis_tlast;
      s1_col       <= column;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: classify and accumulate (both saturating)
  // -------------------------------------------------------------------------
  logic                         hit;
  logic [hcs_pkg::CNT_W-1:0]    pixel_total;
  logic [hcs_pkg::SUM_W-1:0]    column_sum;
  logic [hcs_pkg::CNT_W-1:0]    pixel_total_next;
  logic [hcs_pkg::SUM_W-1:0]    column_sum_next;
  logic [hcs_pkg::SUM_W:0]      sum_wide;
  logic                         r2_valid;
  logic [hcs_pkg::CNT_W-1:0]    r2_cnt;
  logic [hcs_pkg::SUM_W-1:0]    r2_sum;

  hcs_classify #(
    .COL_W (COL_W)
  ) u_classify (
    .thr        (thr),
    .hue        (s1_hue),
    .saturation (s1_sat),
    .brightness (s1_val),
    .column     (s1_col),
    .hit        (hit)
  );

  assign sum_wide = {1'b0, column_sum} + (hcs_pkg::SUM_W + 1)'(s1_col);

  always_comb begin
    pixel_total_next = pixel_total;
    column_sum_next  = column_sum;
    if (hit) begin
      if (pixel_total < COUNT_LIMIT) begin
        pixel_total_next = pixel_total + hcs_pkg::CNT_W'(1);
      end
      if (sum_wide > {1'b0, hcs_pkg::SUM_LIMIT}) begin
        column_sum_next = hcs_pkg::SUM_LIMIT;
      end else begin
        column_sum_next = sum_wide[hcs_pkg::SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= '0;
      column_sum  <= '0;
      r2_valid    <= 1'b0;
    end else if (advance) begin
      r2_valid <= s1_valid && s1_frame_end;
      if (s1_valid) begin
        if (s1_frame_end) begin
          pixel_total <= '0;
          column_sum  <= '0;
        end else begin
          pixel_total <= pixel_total_next;
          column_sum  <= column_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_frame_end) begin
      r2_cnt <= pixel_total_next;
      r2_sum <= column_sum_next;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: window bounds times count, (half -/+ tol) * cnt
  // -------------------------------------------------------------------------
  logic signed [11:0] coef_lo;
  logic        [10:0] coef_hi;
  logic signed [33:0] r3_lo;
  logic        [31:0] r3_hi;
  logic [hcs_pkg::CNT_W-1:0] r3_cnt;
  logic [hcs_pkg::SUM_W-1:0] r3_sum;

  assign coef_lo = $signed({2'b00, row_width[10:1]}) - $signed({3'b000, tolerance});
  assign coef_hi = {1'b0, row_width[10:1]} + {2'b00, tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else if (advance) begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && r2_valid) begin
      r3_lo  <= 34'(coef_lo) * 34'($signed({1'b0, r2_cnt}));
      r3_hi  <= 32'(coef_hi) * 32'(r2_cnt);
      r3_cnt <= r2_cnt;
      r3_sum <= r2_sum;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: decision into the output register
  // -------------------------------------------------------------------------
  hcs_pkg::dir_t             dir_next;
  hcs_pkg::dir_t             out_dir;
  logic [hcs_pkg::CNT_W-1:0] out_cnt;

  always_comb begin
    if (r3_cnt == '0) begin
      dir_next = hcs_pkg::DIR_SEARCH;
    end else if ($signed({4'b0000, r3_sum}) < r3_lo) begin
      dir_next = hcs_pkg::DIR_LEFT;
    end else if ({2'b00, r3_sum} > r3_hi) begin
      dir_next = hcs_pkg::DIR_RIGHT;
    end else begin
      dir_next = hcs_pkg::DIR_STRAIGHT;
    end
  end

  // Loaded when stage 3 holds a result and the slot is free; otherwise the
  // held result simply waits for its handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && r3_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && r3_valid) begin
      out_dir <= dir_next;
      out_cnt <= r3_cnt;
    end
  end

  assign m_axis_tdata = {1'b0, out_cnt, out_dir};

`ifndef ASSERT_OFF
  // Search is reported exactly when the frame had no line pixel.
  a_search_iff_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_dir == hcs_pkg::DIR_SEARCH) == (out_cnt == '0)))
    else $error("search flag disagrees with line pixel count");

  // A frame end leaves both accumulators cleared.
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_frame_end) |=> (pixel_total == '0 && column_sum == '0))
    else $error("accumulators not cleared after frame end");

  // A row or frame end sends the column back to zero.
  a_column_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_axis_tuser || s_axis_tlast)) |=> (column == '0))
    else $error("column not restarted after row end");

  // The count never passes its saturation limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    pixel_total <= COUNT_LIMIT)
    else $error("line pixel count beyond limit");
`endif

endmodule

// ----- dv/hsv_centroid_steering_top_tb.sv -----
// ----------------------------------------------------------------------------
// hsv_centroid_steering_top_tb
// Self-checking bench for the HSV centroid steering block: pixel stream in,
// one steering transaction out per frame. A behavioral model of the classifier
// and accumulators predicts every result not written by hand. A short directed
// plan covers the corners, then random frames run under several register
// settings and three idle/stall mixes.
// ----------------------------------------------------------------------------
module hsv_centroid_steering_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  // Line pixel count saturates at the frame size, capped to the field width
  localparam int unsigned COUNT_CAP  = (MAX_WIDTH * MAX_HEIGHT > 2097151) ?
                                       2097151 : MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned SUM_CAP    = 32'h3FFF_FFFF;
  localparam int          CYCLE_LIMIT   = 200000;
  // Pipeline is four deep; idle time to let it drain before touching registers
  localparam int          SETTLE_CYCLES = 8;
  // Pixel budget for the whole run, long row included
  localparam int          RANDOM_ITEMS  = 1950;
  localparam int          LONG_ROW      = 1100;

  // One pixel as it travels on the slave stream
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bright;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  // One steering result
  typedef struct packed {
    hcs_pkg::dir_t             dir;
    logic [hcs_pkg::CNT_W-1:0] count;
  } steer_t;

  // Directed plan entry: either a register write or a pixel, with an
  // optional hand-written result for the frame-end pixels that are obvious
  typedef struct packed {
    bit          is_write;
    logic [2:0]  reg_idx;
    logic [10:0] reg_val;
    pixel_t      px;
    bit          fixed;
    steer_t      want;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] hue, [15:8] saturation, [23:16] brightness
  logic        s_axis_tuser  = 1'b0; // [0] row_end
  logic        s_axis_tlast  = 1'b0; // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [1:0] direction, [22:2] line_pixels, [23] zero
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index     = '0;
  logic [10:0] cfg_data      = '0;

  always #10 clk = ~clk;

  hsv_centroid_steering_top #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  steer_t pending_steer [$];  // predicted results, oldest first
  int     failures      = 0;
  int     pixels_sent   = 0;
  int     cycles        = 0;
  int     src_idle_pct  = 18; // chance per slot that the pixel source holds off
  int     sink_idle_pct = 86; // chance per cycle that the result sink stalls

  // Model copy of the registers (as masked by the block) and accumulators
  logic [10:0]               row_width_q;
  logic [8:0]                tol_q;
  logic [7:0]                hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
  logic [9:0]                col_q;
  logic [hcs_pkg::CNT_W-1:0] cnt_q;
  logic [hcs_pkg::SUM_W-1:0] sum_q;

  // --------------------------------------------------------------------------
  // Steering model: classify one pixel, accumulate, and on frame end
  // return 1 with the direction and count. Direction is found by
  // cross-multiplying, same as the block, so no rounding creeps in.
  // --------------------------------------------------------------------------
  function automatic bit steer_for_pixel(input pixel_t p, output steer_t r);
    int unsigned lo_col, hi_col, col;
    longint      half, tol, cnt, sum;
    bit          hit;
    lo_col = (3 * row_width_q) / 10;
    hi_col = (7 * row_width_q) / 10;
    col    = col_q;
    hit = p.hue >= hue_lo && p.hue <= hue_hi &&
          p.sat >= sat_lo && p.sat <= sat_hi &&
          p.bright >= val_lo && p.bright <= val_hi &&
          col >= lo_col && col < hi_col;
    if (hit) begin
      if (cnt_q < COUNT_CAP) cnt_q = cnt_q + 1'b1;
      if (sum_q > SUM_CAP - col) sum_q = SUM_CAP;
      else sum_q = hcs_pkg::SUM_W'(sum_q + col);
    end
    // Column returns to zero on either marker, or wraps at MAX_WIDTH
    if (p.row_end || p.frame_end || col + 1 >= MAX_WIDTH) col_q = '0;
    else col_q = col_q + 1'b1;
    r = '0;
    if (!p.frame_end) return 1'b0;
    half = row_width_q / 2;
    tol  = tol_q;
    cnt  = cnt_q;
    sum  = sum_q;
    if (cnt == 0) r.dir = hcs_pkg::DIR_SEARCH;
    else if (sum < (half - tol) * cnt) r.dir = hcs_pkg::DIR_LEFT;
    else if (sum > (half + tol) * cnt) r.dir = hcs_pkg::DIR_RIGHT;
    else r.dir = hcs_pkg::DIR_STRAIGHT;
    r.count = cnt_q;
    cnt_q = '0;
    sum_q = '0;
    return 1'b1;
  endfunction

  // Register write as the block sees it: upper bits beyond each field dropped
  function automatic void apply_reg(input logic [2:0] idx, input logic [10:0] val);
    case (idx)
      hcs_pkg::REG_ROW_WIDTH: row_width_q = val;
      hcs_pkg::REG_TOLERANCE: tol_q       = val[8:0];
      hcs_pkg::REG_HUE_MIN:   hue_lo      = val[7:0];
      hcs_pkg::REG_HUE_MAX:   hue_hi      = val[7:0];
      hcs_pkg::REG_SAT_MIN:   sat_lo      = val[7:0];
      hcs_pkg::REG_SAT_MAX:   sat_hi      = val[7:0];
      hcs_pkg::REG_VAL_MIN:   val_lo      = val[7:0];
      hcs_pkg::REG_VAL_MAX:   val_hi      = val[7:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed plan helpers
  // --------------------------------------------------------------------------
  function automatic plan_row_t pixel_row(input logic [7:0] h, s, v, input logic re, fe);
    pixel_row    = '0;
    pixel_row.px = '{h, s, v, re, fe};
  endfunction

  function automatic plan_row_t pixel_row_fixed(input logic [7:0] h, s, v,
                                                input logic re, fe,
                                                input hcs_pkg::dir_t d,
                                                input logic [hcs_pkg::CNT_W-1:0] n);
    pixel_row_fixed       = pixel_row(h, s, v, re, fe);
    pixel_row_fixed.fixed = 1'b1;
    pixel_row_fixed.want  = '{d, n};
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [10:0] val);
    reg_row          = '0;
    reg_row.is_write = 1'b1;
    reg_row.reg_idx  = idx;
    reg_row.reg_val  = val;
  endfunction

  // Channel value: mostly inside the current bounds so frames carry line
  // pixels, otherwise anywhere in 0..255
  function automatic logic [7:0] pick_channel(input logic [7:0] lo, hi);
    if (lo <= hi && $urandom_range(99) < 70) return 8'($urandom_range(hi, lo));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic pixel_t rand_pixel(input logic re, fe);
    rand_pixel = '{pick_channel(hue_lo, hue_hi), pick_channel(sat_lo, sat_hi),
                   pick_channel(val_lo, val_hi), re, fe};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. All of them are entered and left at a falling edge; inputs
  // change there and handshakes are sampled at the rising edge.
  // --------------------------------------------------------------------------

  // Push one pixel transaction. tvalid stays high straight into the next
  // pixel unless the source decides to hold off.
  task automatic send_pixel(input pixel_t p, input bit fixed, input steer_t want);
    steer_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.bright, p.sat, p.hue};
    s_axis_tuser  <= p.row_end;
    s_axis_tlast  <= p.frame_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (steer_for_pixel(p, got)) pending_steer.push_back(fixed ? want : got);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stop the stream, wait for every predicted result, then let trailing
  // non-end pixels finish accumulating during an idle wait.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_steer.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One config transaction; cfg_valid is left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [10:0] w, tol, hlo, hhi, slo, shi, vlo, vhi);
    settle();
    write_reg(hcs_pkg::REG_ROW_WIDTH, w);
    write_reg(hcs_pkg::REG_TOLERANCE, tol);
    write_reg(hcs_pkg::REG_HUE_MIN, hlo);
    write_reg(hcs_pkg::REG_HUE_MAX, hhi);
    write_reg(hcs_pkg::REG_SAT_MIN, slo);
    write_reg(hcs_pkg::REG_SAT_MAX, shi);
    write_reg(hcs_pkg::REG_VAL_MIN, vlo);
    write_reg(hcs_pkg::REG_VAL_MAX, vhi);
    cfg_valid <= 1'b0;
  endtask

  // Bounds for one channel: usually a sensible window, sometimes the full
  // range, sometimes empty (min above max). Spare upper data bits are
  // filled with junk that the block should drop.
  task automatic pick_bounds(input int top, input bit empty, output logic [10:0] lo, hi);
    int r;
    r = $urandom_range(99);
    if (empty || r < 8) begin
      lo = 11'($urandom_range(top, 1));
      hi = 11'($urandom_range(lo - 1, 0));
    end else if (r < 20) begin
      lo = '0;
      hi = 11'(top);
    end else begin
      lo = 11'($urandom_range(top / 2, 0));
      hi = 11'($urandom_range(top, lo));
    end
    lo = lo | (11'($urandom_range(7, 0)) << 8);
    hi = hi | (11'($urandom_range(7, 0)) << 8);
  endtask

  // Setting number k steers toward the corners in turn: zero, one and
  // over-range row widths, zero and maximum tolerance, an empty hue window.
  task automatic random_setting(input int k);
    logic [10:0] w, tol, hlo, hhi, slo, shi, vlo, vhi;
    case (k % 8)
      1:       w = 11'd0;
      3:       w = 11'd1;
      5:       w = 11'd2047;
      default: w = 11'($urandom_range(40, 5));
    endcase
    if (k % 8 == 2) tol = 11'd511;
    else if (k % 8 == 4) tol = 11'd0;
    else tol = 11'($urandom_range(6, 0));
    tol = tol | (11'($urandom_range(3, 0)) << 9);
    pick_bounds(179, k % 8 == 6, hlo, hhi);
    pick_bounds(255, 1'b0, slo, shi);
    pick_bounds(255, 1'b0, vlo, vhi);
    load_setting(w, tol, hlo, hhi, slo, shi, vlo, vhi);
  endtask

  // A tidy frame has 1..3 rows of exactly row_width pixels (short rows when
  // the width is zero or far too wide to walk). Otherwise it is noise:
  // random row ends and a stray frame end here and there.
  task automatic run_frame(input bit tidy);
    int  rows, len;
    bit  re, fe;
    rows = tidy ? $urandom_range(3, 1) : 1;
    for (int r = 0; r < rows; r++) begin
      if (tidy && row_width_q >= 1 && row_width_q <= 64) len = row_width_q;
      else len = $urandom_range(30, 1);
      for (int c = 0; c < len; c++) begin
        if (tidy) begin
          re = (c == len - 1);
          fe = re && (r == rows - 1);
        end else begin
          re = ($urandom_range(99) < 15);
          fe = (c == len - 1) || ($urandom_range(99) < 3);
        end
        send_pixel(rand_pixel(re, fe), 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, changed at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    steer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_steer.size() == 0) begin
        $error("unexpected steering result, tdata %h", m_axis_tdata);
        failures++;
      end else begin
        want = pending_steer.pop_front();
        if (m_axis_tdata[1:0] !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, m_axis_tdata[1:0]);
          failures++;
        end
        if (m_axis_tdata[22:2] !== want.count) begin
          $error("line_pixels: expected %0d, got %0d", want.count, m_axis_tdata[22:2]);
          failures++;
        end
        if (m_axis_tdata[23] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_axis_tdata[23]);
          failures++;
        end
      end
    end
  end

  // Watchdog: a missing result or a dead handshake ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan [$];
    int        setting_no;
    int        target;
    int        n_frames;
    logic [10:0] long_tol;

    row_width_q = hcs_pkg::RST_ROW_WIDTH;
    tol_q       = hcs_pkg::RST_TOLERANCE;
    hue_lo      = hcs_pkg::RST_HUE_MIN;
    hue_hi      = hcs_pkg::RST_HUE_MAX;
    sat_lo      = hcs_pkg::RST_SAT_MIN;
    sat_hi      = hcs_pkg::RST_SAT_MAX;
    val_lo      = hcs_pkg::RST_VAL_MIN;
    val_hi      = hcs_pkg::RST_VAL_MAX;
    col_q       = '0;
    cnt_q       = '0;
    sum_q       = '0;
    setting_no  = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed plan. With row width 9 the band is columns 2..5 and the
    // centre is 4, so column 2/3 steer left, 4 is straight, 5 is right.
    plan = '{
      // reset registers: column 0 is far outside the 192..447 band
      pixel_row_fixed(8'd25, 8'd200, 8'd200, 1'b0, 1'b1, hcs_pkg::DIR_SEARCH, '0),
      reg_row(hcs_pkg::REG_ROW_WIDTH, 11'd9),
      reg_row(hcs_pkg::REG_TOLERANCE, 11'd0),
      // channel extremes, then a hit on every lower bound at column 3
      pixel_row(8'd0,   8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row(8'd255, 8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row(8'd25,  8'd0,   8'd200, 1'b0, 1'b0),
      pixel_row(8'd20,  8'd100, 8'd100, 1'b0, 1'b1),
      // misses (hue above 179, just below/above bounds), then a hit on
      // every upper bound at column 5
      pixel_row(8'd180, 8'd255, 8'd0,   1'b0, 1'b0),
      pixel_row(8'd179, 8'd255, 8'd255, 1'b0, 1'b0),
      pixel_row(8'd25,  8'd99,  8'd200, 1'b0, 1'b0),
      pixel_row(8'd25,  8'd200, 8'd99,  1'b0, 1'b0),
      pixel_row(8'd31,  8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row(8'd30,  8'd255, 8'd255, 1'b0, 1'b1),
      // row end alone, then row and frame end together: both at column 0
      pixel_row(8'd25, 8'd200, 8'd200, 1'b1, 1'b0),
      pixel_row_fixed(8'd25, 8'd200, 8'd200, 1'b1, 1'b1, hcs_pkg::DIR_SEARCH, '0),
      // tolerance wider than the centre: column 2 no longer reads as left
      reg_row(hcs_pkg::REG_TOLERANCE, 11'd511),
      pixel_row(8'd25, 8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row(8'd25, 8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row(8'd25, 8'd200, 8'd200, 1'b0, 1'b1),
      // empty hue window: nothing can count
      reg_row(hcs_pkg::REG_HUE_MIN, 11'd31),
      pixel_row(8'd25, 8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row(8'd30, 8'd200, 8'd200, 1'b0, 1'b0),
      pixel_row_fixed(8'd31, 8'd200, 8'd200, 1'b0, 1'b1, hcs_pkg::DIR_SEARCH, '0)
    };

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_pixel(plan[i].px, plan[i].fixed, plan[i].want);
      end
    end

    // Random frames in three idle mixes: slow sink, slow source, full rate
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct  = 86;
        sink_idle_pct = 18;
      end else if (phase == 2) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // One full-width row with no row end: the column has to wrap at
        // MAX_WIDTH and the wide band collects a few hundred line pixels
        long_tol = 11'($urandom_range(40, 0));
        load_setting(11'd1024, long_tol, 11'd0, 11'd179, 11'd0, 11'd255,
                     11'd0, 11'd255);
        for (int c = 0; c < LONG_ROW; c++)
          send_pixel(rand_pixel(1'b0, c == LONG_ROW - 1), 1'b0, '0);
      end
      // The random budget is split evenly; the long row comes on top of
      // the last share so the run stays near the total pixel budget
      target = ((RANDOM_ITEMS - LONG_ROW) * (phase + 1)) / 3 +
               ((phase == 2) ? LONG_ROW : 0);
      while (pixels_sent < target) begin
        random_setting(setting_no);
        setting_no++;
        n_frames = $urandom_range(5, 2);
        for (int f = 0; f < n_frames && pixels_sent < target; f++)
          run_frame($urandom_range(99) < 80);
      end
    end

    settle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
